/* rtl/midpoint_ellipse_points_assert.svh */
// Assertion macros shared by the midpoint ellipse point generator.
`ifndef MIDPOINT_ELLIPSE_POINTS_ASSERT_SVH
`define MIDPOINT_ELLIPSE_POINTS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MEP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mep_pkg.sv */
// Package with the control word types and microcode program of the ellipse generator.
`default_nettype none

package mep_pkg;

  localparam int COORD_BITS_DEFAULT = 11;
  localparam int PC_W = 5;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_STEP  = 5'd4;
  localparam logic [PC_W-1:0] PC_CHKY  = 5'd15;
  localparam logic [PC_W-1:0] PC_R1    = 5'd20;
  localparam logic [PC_W-1:0] PC_FIN   = 5'd24;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO
  } phase_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RXRX,
    MUL_RYRY,
    MUL_A_RY,
    MUL_X_B,
    MUL_Y_A,
    MUL_X_X1,
    MUL_YM1_SQ,
    MUL_T_B,
    MUL_U_A,
    MUL_A_B,
    MUL_B_2X3,
    MUL_A_2M2Y,
    MUL_A_3M2Y,
    MUL_B_2P2X
  } mul_sel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_A,
    DST_B,
    DST_T,
    DST_U,
    DST_ACC,
    DST_ACC_BQ,
    DST_ACC_ADD,
    DST_ACC_DEC,
    DST_DEC_INIT,
    DST_DEC_R2,
    DST_R1UPD,
    DST_R2UPD,
    DST_IDLE
  } dst_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PP,
    EMIT_MP,
    EMIT_PM,
    EMIT_MM,
    EMIT_FIN
  } emit_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_END,
    JC_IDLE,
    JC_PH2,
    JC_LT,
    JC_YNEG
  } jcond_t;

  typedef struct packed {
    mul_sel_t        mul;
    dst_t            dst;
    emit_t           emit;
    jcond_t          jc;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{MUL_NONE, DST_NONE, EMIT_NONE, JC_NEXT, PC_START};
    case (pc)
      5'd0:  cw.mul = MUL_RXRX;
      5'd1:  begin cw.mul = MUL_RYRY; cw.dst = DST_A; end
      5'd2:  begin cw.mul = MUL_A_RY; cw.dst = DST_B; end
      5'd3:  begin cw.dst = DST_DEC_INIT; cw.jc = JC_END; end
      5'd4:  begin cw.jc = JC_IDLE; cw.target = PC_FIN; end
      5'd5:  begin cw.jc = JC_PH2; cw.target = PC_CHKY; end
      5'd6:  cw.mul = MUL_X_B;
      5'd7:  begin cw.mul = MUL_Y_A; cw.dst = DST_ACC; end
      5'd8:  begin cw.jc = JC_LT; cw.target = PC_R1; end
      5'd9:  cw.mul = MUL_X_X1;
      5'd10: begin cw.mul = MUL_YM1_SQ; cw.dst = DST_T; end
      5'd11: begin cw.mul = MUL_T_B; cw.dst = DST_U; end
      5'd12: begin cw.mul = MUL_U_A; cw.dst = DST_ACC_BQ; end
      5'd13: begin cw.mul = MUL_A_B; cw.dst = DST_ACC_ADD; end
      5'd14: cw.dst = DST_DEC_R2;
      5'd15: begin cw.jc = JC_YNEG; cw.target = PC_FIN; end
      5'd16: begin cw.mul = MUL_A_3M2Y; cw.emit = EMIT_PP; end
      5'd17: begin cw.mul = MUL_B_2P2X; cw.dst = DST_ACC_DEC; cw.emit = EMIT_MP; end
      5'd18: cw.emit = EMIT_PM;
      5'd19: begin cw.dst = DST_R2UPD; cw.emit = EMIT_MM; cw.jc = JC_END; end
      5'd20: begin cw.mul = MUL_B_2X3; cw.emit = EMIT_PP; end
      5'd21: begin cw.mul = MUL_A_2M2Y; cw.dst = DST_ACC_DEC; cw.emit = EMIT_MP; end
      5'd22: cw.emit = EMIT_PM;
      5'd23: begin cw.dst = DST_R1UPD; cw.emit = EMIT_MM; cw.jc = JC_END; end
      5'd24: begin cw.dst = DST_IDLE; cw.emit = EMIT_FIN; cw.jc = JC_END; end
      default: cw.jc = JC_END;
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* rtl/midpoint_ellipse_points.sv */
// Midpoint ellipse point generator driven by a microcoded sequencer and a shared multiplier.
//
// Usage: command words enter on cmd_valid/cmd_stall; result words leave on
// res_valid/res_stall through one output register. A start word (kind = 0)
// loads center and radii and produces no result; it keeps the block busy
// while its program runs. A step word (kind = 1) produces four mirrored
// pixels, the fourth marked last_of_step, or one finished marker once the
// curve is done. A step runs a different program path in region one, on the
// step that enters region two, in region two, and for the finished marker; the
// next word is accepted once that program has ended and busy has fallen. Each
// result word is registered and appears in the cycle after its emitting
// program step. The single multiplier and the one-word output register shape
// the program: each program step does at most one multiplication and emits
// at most one word.
// cmd_stall is high while a program runs. When the receiver stalls with a
// word waiting, the program freezes on its next emitting step. Reset empties
// the output register and leaves the block with no ellipse, so a step word
// then returns the finished marker.
`default_nettype none

module midpoint_ellipse_points #(
  parameter int COORD_BITS = mep_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  output logic                              cmd_stall,
  input  wire logic                         kind,
  input  wire logic [COORD_BITS-1:0]        center_x,
  input  wire logic [COORD_BITS-1:0]        center_y,
  input  wire logic [COORD_BITS-2:0]        radius_x,
  input  wire logic [COORD_BITS-2:0]        radius_y,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic signed [COORD_BITS+1:0]      pixel_x,
  output logic signed [COORD_BITS+1:0]      pixel_y,
  output logic                              point_valid,
  output logic                              last_of_step,
  output logic                              finished
);

  `include "midpoint_ellipse_points_assert.svh"

  localparam int RAD_W = COORD_BITS - 1;
  localparam int PIX_W = COORD_BITS + 2;
  localparam int SQ_W  = 2 * RAD_W;
  localparam int XW    = RAD_W + 2;
  localparam int YW    = RAD_W + 2;
  localparam int MUL_W = 2 * RAD_W + 3;
  localparam int DEC_W = 4 * RAD_W + 8;

  localparam logic signed [MUL_W-1:0] K1 = MUL_W'(1);
  localparam logic signed [MUL_W-1:0] K2 = MUL_W'(2);
  localparam logic signed [MUL_W-1:0] K3 = MUL_W'(3);

  logic                         busy;
  logic                         busy_next;
  logic [mep_pkg::PC_W-1:0]     pc;
  logic [mep_pkg::PC_W-1:0]     pc_next;
  mep_pkg::phase_t              phase;
  mep_pkg::phase_t              phase_next;
  logic                         res_valid_next;
  mep_pkg::ctrl_t               cw;
  logic                         cmd_accept;
  logic                         hold;
  logic                         run;
  logic                         taken;

  logic [COORD_BITS-1:0]        cx;
  logic [COORD_BITS-1:0]        cy;
  logic [RAD_W-1:0]             rad_x;
  logic [RAD_W-1:0]             rad_y;
  logic [SQ_W-1:0]              rx_sq;
  logic [SQ_W-1:0]              ry_sq;
  logic [XW-1:0]                cur_x;
  logic signed [YW-1:0]         cur_y;
  logic signed [DEC_W-1:0]      decision;
  logic signed [DEC_W-1:0]      acc;
  logic signed [DEC_W-1:0]      prod;
  logic signed [MUL_W-1:0]      t;
  logic signed [MUL_W-1:0]      u;

  logic signed [MUL_W-1:0]      x_s;
  logic signed [MUL_W-1:0]      y_s;
  logic signed [MUL_W-1:0]      rx_s;
  logic signed [MUL_W-1:0]      ry_s;
  logic signed [MUL_W-1:0]      a_s;
  logic signed [MUL_W-1:0]      b_s;
  logic signed [MUL_W-1:0]      mul_a;
  logic signed [MUL_W-1:0]      mul_b;
  logic signed [2*MUL_W-1:0]    prod_full;
  logic signed [DEC_W-1:0]      a_d;
  logic signed [DEC_W-1:0]      b_d;
  logic signed [PIX_W-1:0]      cx_p;
  logic signed [PIX_W-1:0]      cy_p;
  logic signed [PIX_W-1:0]      x_p;
  logic signed [PIX_W-1:0]      y_p;

  assign cw         = mep_pkg::ucode(pc);
  assign cmd_stall  = busy;
  assign cmd_accept = cmd_valid && !busy;
  assign hold       = (cw.emit != mep_pkg::EMIT_NONE) && res_valid && res_stall;
  assign run        = busy && !hold;

  assign x_s  = $signed({{(MUL_W-XW){1'b0}}, cur_x});
  assign y_s  = MUL_W'(cur_y);
  assign rx_s = $signed({{(MUL_W-RAD_W){1'b0}}, rad_x});
  assign ry_s = $signed({{(MUL_W-RAD_W){1'b0}}, rad_y});
  assign a_s  = $signed({{(MUL_W-SQ_W){1'b0}}, rx_sq});
  assign b_s  = $signed({{(MUL_W-SQ_W){1'b0}}, ry_sq});
  assign a_d  = $signed({{(DEC_W-SQ_W){1'b0}}, rx_sq});
  assign b_d  = $signed({{(DEC_W-SQ_W){1'b0}}, ry_sq});
  assign cx_p = $signed({2'b00, cx});
  assign cy_p = $signed({2'b00, cy});
  assign x_p  = $signed({{(PIX_W-XW){1'b0}}, cur_x});
  assign y_p  = PIX_W'(cur_y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      mep_pkg::MUL_RXRX:   begin mul_a = rx_s;            mul_b = rx_s; end
      mep_pkg::MUL_RYRY:   begin mul_a = ry_s;            mul_b = ry_s; end
      mep_pkg::MUL_A_RY:   begin mul_a = a_s;             mul_b = ry_s; end
      mep_pkg::MUL_X_B:    begin mul_a = x_s;             mul_b = b_s; end
      mep_pkg::MUL_Y_A:    begin mul_a = y_s;             mul_b = a_s; end
      mep_pkg::MUL_X_X1:   begin mul_a = x_s;             mul_b = x_s + K1; end
      mep_pkg::MUL_YM1_SQ: begin mul_a = y_s - K1;        mul_b = y_s - K1; end
      mep_pkg::MUL_T_B:    begin mul_a = t;               mul_b = b_s; end
      mep_pkg::MUL_U_A:    begin mul_a = u;               mul_b = a_s; end
      mep_pkg::MUL_A_B:    begin mul_a = a_s;             mul_b = b_s; end
      mep_pkg::MUL_B_2X3:  begin mul_a = b_s;             mul_b = (x_s <<< 1) + K3; end
      mep_pkg::MUL_A_2M2Y: begin mul_a = a_s;             mul_b = K2 - (y_s <<< 1); end
      mep_pkg::MUL_A_3M2Y: begin mul_a = a_s;             mul_b = K3 - (y_s <<< 1); end
      mep_pkg::MUL_B_2P2X: begin mul_a = b_s;             mul_b = K2 + (x_s <<< 1); end
      default:             begin mul_a = '0;              mul_b = '0; end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    case (cw.jc)
      mep_pkg::JC_IDLE: taken = (phase == mep_pkg::PH_IDLE);
      mep_pkg::JC_PH2:  taken = (phase == mep_pkg::PH_TWO);
      mep_pkg::JC_LT:   taken = (acc < prod);
      mep_pkg::JC_YNEG: taken = cur_y[YW-1];
      default:          taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_next = busy;
    pc_next   = pc;
    if (!busy) begin
      if (cmd_accept) begin
        busy_next = 1'b1;
        pc_next   = (kind == mep_pkg::KIND_STEP) ? mep_pkg::PC_STEP : mep_pkg::PC_START;
      end
    end else if (run) begin
      if (cw.jc == mep_pkg::JC_END) begin
        busy_next = 1'b0;
      end else if (taken) begin
        pc_next = cw.target;
      end else begin
        pc_next = pc + mep_pkg::PC_W'(1);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    if (cmd_accept && kind == mep_pkg::KIND_START) begin
      phase_next = mep_pkg::PH_ONE;
    end else if (run && cw.dst == mep_pkg::DST_DEC_R2) begin
      phase_next = mep_pkg::PH_TWO;
    end else if (run && cw.dst == mep_pkg::DST_IDLE) begin
      phase_next = mep_pkg::PH_IDLE;
    end
  end

  always_comb begin
    if (run && cw.emit != mep_pkg::EMIT_NONE) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= mep_pkg::PC_START;
      phase     <= mep_pkg::PH_IDLE;
      res_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      pc        <= pc_next;
      phase     <= phase_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept && kind == mep_pkg::KIND_START) begin
      cx    <= center_x;
      cy    <= center_y;
      rad_x <= radius_x;
      rad_y <= radius_y;
      cur_x <= '0;
      cur_y <= $signed({2'b00, radius_y});
    end else if (run) begin
      if (cw.mul != mep_pkg::MUL_NONE) begin
        prod <= DEC_W'(prod_full);
      end
      case (cw.dst)
        mep_pkg::DST_A:        rx_sq <= prod[SQ_W-1:0];
        mep_pkg::DST_B:        ry_sq <= prod[SQ_W-1:0];
        mep_pkg::DST_T:        t <= $signed(prod[MUL_W-1:0]);
        mep_pkg::DST_U:        u <= $signed(prod[MUL_W-1:0]);
        mep_pkg::DST_ACC:      acc <= prod;
        mep_pkg::DST_ACC_BQ:   acc <= prod + (b_d >>> 2);
        mep_pkg::DST_ACC_ADD:  acc <= acc + prod;
        mep_pkg::DST_ACC_DEC:  acc <= decision + prod;
        mep_pkg::DST_DEC_INIT: decision <= b_d - prod + (a_d >>> 2);
        mep_pkg::DST_DEC_R2:   decision <= acc - prod;
        mep_pkg::DST_R1UPD: begin
          if (decision[DEC_W-1]) begin
            decision <= acc;
          end else begin
            decision <= acc + prod;
            cur_y    <= cur_y - YW'(1);
          end
          cur_x <= cur_x + XW'(1);
        end
        mep_pkg::DST_R2UPD: begin
          if (decision[DEC_W-1]) begin
            decision <= acc + prod;
            cur_x    <= cur_x + XW'(1);
          end else begin
            decision <= acc;
          end
          cur_y <= cur_y - YW'(1);
        end
        default: begin
        end
      endcase
      case (cw.emit)
        mep_pkg::EMIT_PP: begin
          pixel_x <= cx_p + x_p; pixel_y <= cy_p + y_p;
          point_valid <= 1'b1; last_of_step <= 1'b0; finished <= 1'b0;
        end
        mep_pkg::EMIT_MP: begin
          pixel_x <= cx_p - x_p; pixel_y <= cy_p + y_p;
          point_valid <= 1'b1; last_of_step <= 1'b0; finished <= 1'b0;
        end
        mep_pkg::EMIT_PM: begin
          pixel_x <= cx_p + x_p; pixel_y <= cy_p - y_p;
          point_valid <= 1'b1; last_of_step <= 1'b0; finished <= 1'b0;
        end
        mep_pkg::EMIT_MM: begin
          pixel_x <= cx_p - x_p; pixel_y <= cy_p - y_p;
          point_valid <= 1'b1; last_of_step <= 1'b1; finished <= 1'b0;
        end
        mep_pkg::EMIT_FIN: begin
          pixel_x <= '0; pixel_y <= '0;
          point_valid <= 1'b0; last_of_step <= 1'b1; finished <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  `MEP_ASSERT_NEXT(a_hold_freezes_pc, clk, rst, busy && hold, $stable(pc),
    "program advanced while its output word was blocked")
  `MEP_ASSERT_IMP(a_marker_shape, clk, rst, res_valid && finished,
    !point_valid && last_of_step, "finished marker carries a pixel or is not last")
  `MEP_ASSERT_NEXT(a_start_region_one, clk, rst,
    cmd_accept && kind == mep_pkg::KIND_START, phase == mep_pkg::PH_ONE,
    "start word did not enter region one")
  `MEP_ASSERT_IMP(a_idle_step_marker, clk, rst,
    cmd_accept && kind == mep_pkg::KIND_STEP && phase == mep_pkg::PH_IDLE,
    ##2 (pc == mep_pkg::PC_FIN), "step on a finished curve did not go to the marker")

endmodule

`default_nettype wire
